>>> hdl/concentric_ring_pixel_color_unit_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros for the concentric ring pixel color unit
// Shared concurrent assertion forms used by the port checker.
// ---------------------------------------------------------------------------
`ifndef CONCENTRIC_RING_PIXEL_COLOR_UNIT_MACROS_SVH
`define CONCENTRIC_RING_PIXEL_COLOR_UNIT_MACROS_SVH

// same-cycle implication, off during reset
`define CRP_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("crp check failed");

// next-cycle implication, off during reset
`define CRP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("crp check failed");

// next-cycle implication, active during reset
`define CRP_ASSERT_RESET(label, clk, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("crp reset check failed");

`endif

>>> hdl/crp_pkg.sv
// ---------------------------------------------------------------------------
// crp_pkg
// Widths, register codes and cell data types of the ring color pipeline.
// ---------------------------------------------------------------------------
package crp_pkg;

  localparam int COORD_BITS = 12;
  localparam int SIZE_W     = 13;                 // image width / height register
  localparam int HALF_W     = SIZE_W - 1;
  localparam int MAXC_W     = (COORD_BITS > HALF_W) ? COORD_BITS : HALF_W;
  localparam int OFF_W      = MAXC_W + 1;         // magnitude of doubled offset
  localparam int DIFF_W     = OFF_W + 1;          // signed doubled offset
  localparam int ROOT_W     = OFF_W + 1;          // root of a*a + b*b
  localparam int RAD_W      = 2 * ROOT_W;
  localparam int REM_W      = ROOT_W + 3;
  localparam int RING_W     = ROOT_W - 3;
  localparam int MOD_W      = 9;                  // color count register
  localparam int COLOR_W    = 8;
  localparam int NSTAGE     = 2 + ROOT_W + RING_W;

  localparam int CFG_ADDR_W = 4;
  localparam int CFG_DATA_W = 32;

  localparam logic [1:0] REG_IMAGE_WIDTH  = 2'd0;
  localparam logic [1:0] REG_IMAGE_HEIGHT = 2'd1;
  localparam logic [1:0] REG_COLOR_COUNT  = 2'd2;

  localparam logic [SIZE_W-1:0] WIDTH_RESET  = SIZE_W'(128);
  localparam logic [SIZE_W-1:0] HEIGHT_RESET = SIZE_W'(128);
  localparam logic [MOD_W-1:0]  COUNT_RESET  = MOD_W'(16);
  localparam logic [MOD_W-1:0]  COUNT_MAX    = MOD_W'(256);

  typedef struct packed {
    logic [RAD_W-1:0]  rad;    // radicand bits not yet consumed, msb first
    logic [REM_W-1:0]  rem;    // partial remainder
    logic [ROOT_W-1:0] root;   // partial root
  } sqrt_t;

  typedef struct packed {
    logic [RING_W-1:0]  bits;  // ring bits not yet consumed, msb first
    logic [COLOR_W-1:0] rem;   // partial remainder
  } mod_t;

endpackage

>>> hdl/concentric_ring_pixel_color_unit.sv
// Path from an accepted item to out_valid: 2 front stages, one root cell per
//   root bit, one remainder cell per ring bit, then the output register.
// Throughput: one item per clock while the skid slot is empty; the whole
//   cell chain holds while the skid slot is full.
// Reset (synchronous, rst_n low): all valid bits clear, the output buffer
//   empties and the registers return to width 128, height 128, 16 colors.
// ---------------------------------------------------------------------------
// concentric_ring_pixel_color_unit
// Maps a pixel coordinate to a palette index forming rings around the center.
// ---------------------------------------------------------------------------
module concentric_ring_pixel_color_unit (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [crp_pkg::COORD_BITS-1:0] in_col,
  input  logic [crp_pkg::COORD_BITS-1:0] in_row,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [crp_pkg::COLOR_W-1:0]    out_color_index,
  input  logic                           cfg_psel,
  input  logic                           cfg_penable,
  input  logic                           cfg_pwrite,
  input  logic [crp_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [crp_pkg::CFG_DATA_W-1:0] cfg_pwdata,
  output logic [crp_pkg::CFG_DATA_W-1:0] cfg_prdata,
  output logic                           cfg_pready
);
  import crp_pkg::*;

  // configuration
  logic [SIZE_W-1:0] width_r;
  logic [SIZE_W-1:0] height_r;
  logic [MOD_W-1:0]  count_r;
  logic              cfg_wr;
  logic [MOD_W-1:0]  modulus;
  logic              small_n;

  // pipeline
  logic              adv;
  logic [NSTAGE-1:0] valid_r;
  logic [DIFF_W-1:0] a_diff;
  logic [DIFF_W-1:0] b_diff;
  logic [OFF_W-1:0]  a_mag_r;
  logic [OFF_W-1:0]  b_mag_r;
  logic [2*OFF_W-1:0] a_sq;
  logic [2*OFF_W-1:0] b_sq;
  sqrt_t             sum_nxt;
  sqrt_t             sum_r;
  sqrt_t             sq_w [ROOT_W+1];
  mod_t              md_w [RING_W+1];

  // output buffer
  logic               push;
  logic               take;
  logic [COLOR_W-1:0] push_data;
  logic               out_valid_r;
  logic               out_valid_nxt;
  logic [COLOR_W-1:0] out_data_r;
  logic [COLOR_W-1:0] out_data_nxt;
  logic               skid_full_r;
  logic               skid_full_nxt;
  logic [COLOR_W-1:0] skid_data_r;
  logic [COLOR_W-1:0] skid_data_nxt;

  // ---- configuration port ----
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= WIDTH_RESET;
      height_r <= HEIGHT_RESET;
      count_r  <= COUNT_RESET;
    end else if (cfg_wr) begin
      case (cfg_paddr[3:2])
        REG_IMAGE_WIDTH:  width_r  <= cfg_pwdata[SIZE_W-1:0];
        REG_IMAGE_HEIGHT: height_r <= cfg_pwdata[SIZE_W-1:0];
        REG_COLOR_COUNT:  count_r  <= cfg_pwdata[MOD_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_paddr[3:2])
      REG_IMAGE_WIDTH:  cfg_prdata = CFG_DATA_W'(width_r);
      REG_IMAGE_HEIGHT: cfg_prdata = CFG_DATA_W'(height_r);
      REG_COLOR_COUNT:  cfg_prdata = CFG_DATA_W'(count_r);
      default:          cfg_prdata = '0;
    endcase
  end

  // saturate the count at 256; below two colors every index is zero
  assign modulus = (count_r > COUNT_MAX) ? COUNT_MAX : count_r;
  assign small_n = (modulus < MOD_W'(2));

  // ---- pipeline control: whole chain moves unless the skid slot is full ----
  assign adv      = !skid_full_r;
  assign in_stall = skid_full_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (adv) begin
      valid_r <= {valid_r[NSTAGE-2:0], in_valid};
    end
  end

  // ---- front: doubled offsets and sum of squares ----
  always_comb begin
    a_diff = DIFF_W'({in_col, 1'b1}) - DIFF_W'({width_r[SIZE_W-1:1], 1'b0});
    b_diff = DIFF_W'({in_row, 1'b1}) - DIFF_W'({height_r[SIZE_W-1:1], 1'b0});
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_mag_r <= a_diff[DIFF_W-1] ? OFF_W'(-a_diff) : a_diff[OFF_W-1:0];
      b_mag_r <= b_diff[DIFF_W-1] ? OFF_W'(-b_diff) : b_diff[OFF_W-1:0];
    end
  end

  assign a_sq = (2*OFF_W)'(a_mag_r) * (2*OFF_W)'(a_mag_r);
  assign b_sq = (2*OFF_W)'(b_mag_r) * (2*OFF_W)'(b_mag_r);

  always_comb begin
    sum_nxt.rad  = RAD_W'(a_sq) + RAD_W'(b_sq);
    sum_nxt.rem  = '0;
    sum_nxt.root = '0;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sum_r <= sum_nxt;
    end
  end

  assign sq_w[0] = sum_r;

  // ---- root cells ----
  for (genvar k = 0; k < ROOT_W; k++) begin : g_sqrt
    crp_sqrt_cell u_sqrt_cell (
      .clk   (clk),
      .en    (adv),
      .d_in  (sq_w[k]),
      .d_out (sq_w[k+1])
    );
  end

  // ring number is the root divided by eight
  assign md_w[0].bits = sq_w[ROOT_W].root[ROOT_W-1:3];
  assign md_w[0].rem  = '0;

  // ---- remainder cells ----
  for (genvar k = 0; k < RING_W; k++) begin : g_mod
    crp_mod_cell u_mod_cell (
      .clk     (clk),
      .en      (adv),
      .modulus (modulus),
      .d_in    (md_w[k]),
      .d_out   (md_w[k+1])
    );
  end

  // ---- output register with skid slot ----
  assign push      = adv && valid_r[NSTAGE-1];
  assign take      = out_valid_r && !out_stall;
  assign push_data = small_n ? '0 : md_w[RING_W].rem;

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    skid_full_nxt = skid_full_r;
    skid_data_nxt = skid_data_r;
    if (skid_full_r) begin
      if (take) begin
        out_data_nxt  = skid_data_r;
        skid_full_nxt = 1'b0;
      end
    end else if (push) begin
      if (!out_valid_r || take) begin
        out_valid_nxt = 1'b1;
        out_data_nxt  = push_data;
      end else begin
        // hold the item aside while the output waits
        skid_full_nxt = 1'b1;
        skid_data_nxt = push_data;
      end
    end else if (take) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      skid_full_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      skid_full_r <= skid_full_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r  <= out_data_nxt;
    skid_data_r <= skid_data_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_color_index = out_data_r;

endmodule

>>> hdl/crp_sqrt_cell.sv
// ---------------------------------------------------------------------------
// crp_sqrt_cell
// One restoring square root step: settles one root bit per cell.
// ---------------------------------------------------------------------------
module crp_sqrt_cell (
  input  logic           clk,
  input  logic           en,
  input  crp_pkg::sqrt_t d_in,
  output crp_pkg::sqrt_t d_out
);
  import crp_pkg::*;

  sqrt_t             cell_r;
  sqrt_t             cell_nxt;
  logic [REM_W-1:0]  cur;
  logic [REM_W-1:0]  trial;
  logic              ge;

  always_comb begin
    // bring down the next two radicand bits, try root*4 + 1
    cur            = {d_in.rem[REM_W-3:0], d_in.rad[RAD_W-1 -: 2]};
    trial          = REM_W'({d_in.root, 2'b01});
    ge             = (cur >= trial);
    cell_nxt.rem   = ge ? (cur - trial) : cur;
    cell_nxt.root  = {d_in.root[ROOT_W-2:0], ge};
    cell_nxt.rad   = d_in.rad << 2;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cell_r <= cell_nxt;
    end
  end

  assign d_out = cell_r;

endmodule

>>> hdl/crp_mod_cell.sv
// ---------------------------------------------------------------------------
// crp_mod_cell
// One restoring remainder step: folds one ring bit into the remainder.
// ---------------------------------------------------------------------------
module crp_mod_cell (
  input  logic                      clk,
  input  logic                      en,
  input  logic [crp_pkg::MOD_W-1:0] modulus,
  input  crp_pkg::mod_t             d_in,
  output crp_pkg::mod_t             d_out
);
  import crp_pkg::*;

  mod_t             cell_r;
  mod_t             cell_nxt;
  logic [MOD_W-1:0] cur;
  logic [MOD_W-1:0] diff;

  always_comb begin
    cur           = {d_in.rem, d_in.bits[RING_W-1]};
    diff          = cur - modulus;
    // remainder stays below the modulus, so it fits the color width
    cell_nxt.rem  = (cur >= modulus) ? diff[COLOR_W-1:0] : cur[COLOR_W-1:0];
    cell_nxt.bits = d_in.bits << 1;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cell_r <= cell_nxt;
    end
  end

  assign d_out = cell_r;

endmodule

>>> hdl/crp_checker.sv
// ---------------------------------------------------------------------------
// crp_checker
// Port-level checks of the ring color unit's output buffering and reset.
// ---------------------------------------------------------------------------
`include "concentric_ring_pixel_color_unit_macros.svh"

module crp_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_stall,
  input logic                        out_valid,
  input logic                        out_stall,
  input logic [crp_pkg::COLOR_W-1:0] out_color_index
);
  import crp_pkg::*;

  // a stalled result holds
  `CRP_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_color_index))

  // input only stalls while a result is waiting at the output
  `CRP_ASSERT_NOW(a_stall_needs_out, clk, rst_n, in_stall, out_valid)

  // a full skid slot stays full while the output is stalled
  `CRP_ASSERT_NEXT(a_skid_holds, clk, rst_n, in_stall && out_stall, in_stall)

  // reset empties the output side
  `CRP_ASSERT_RESET(a_reset_clears, clk, !rst_n, !out_valid && !in_stall)

endmodule

bind concentric_ring_pixel_color_unit crp_checker u_crp_checker (.*);
